// ----- rtl/core/fpa_pkg.sv -----
// Shared codes, character constants and helpers for the ASCII formatter.
`default_nettype none
package fpa_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned NDIG    = 10;
  localparam int unsigned BCD_W   = 4 * NDIG;
  localparam int unsigned IDX_W   = 4;

  typedef logic [2:0]       op_t;
  typedef logic [3:0]       nib_t;
  typedef logic [7:0]       char_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam op_t OP_LIT   = 3'd0;
  localparam op_t OP_DEC   = 3'd1;
  localparam op_t OP_DECI  = 3'd2;
  localparam op_t OP_CENTI = 3'd3;
  localparam op_t OP_MILLI = 3'd4;
  localparam op_t OP_HEX2  = 3'd5;
  localparam op_t OP_HEX4  = 3'd6;
  localparam op_t OP_HEX8  = 3'd7;

  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_UPPER = 8'h41;
  localparam char_t CH_MINUS = 8'h2d;
  localparam char_t CH_POINT = 8'h2e;

  function automatic char_t hex_char(input nib_t nib);
    char_t c;
    if (nib < 4'd10) begin
      c = CH_ZERO + {4'b0, nib};
    end else begin
      c = CH_UPPER + {4'b0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/fpa_bcd_conv.sv -----
// Serial shift-and-add-3 binary to BCD converter, one bit per cycle.
`default_nettype none
module fpa_bcd_conv
  import fpa_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [VAL_W-1:0] bin,
  output logic                  done,
  output logic [BCD_W-1:0]      bcd
);

  logic [BCD_W+VAL_W-1:0] shift_r, shift_nxt;
  logic [4:0]             cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [BCD_W-1:0]       adj;
  nib_t                   dig;

  always_comb begin
    adj = '0;
    for (int i = 0; i < NDIG; i++) begin
      dig = shift_r[VAL_W + 4*i +: 4];
      adj[4*i +: 4] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_comb begin
    shift_nxt = shift_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (start) begin
      shift_nxt = {{BCD_W{1'b0}}, bin};
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = {adj[BCD_W-2:0], shift_r[VAL_W-1:0], 1'b0};
      cnt_nxt   = cnt_r + 5'd1;
      if (cnt_r == 5'(VAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
  end

  assign done = done_r;
  assign bcd  = shift_r[BCD_W+VAL_W-1:VAL_W];

endmodule
`default_nettype wire

// ----- rtl/core/fixed_point_to_ascii_formatter.sv -----
// Top level: request sequencer, BCD converter and character output register.
// Sequencing: literal and hex requests go straight to character output after acceptance;
// decimal requests first wait for the 32-step serial BCD conversion to finish.
// Throughput: one character per cycle while out_tready is not held low; input is not ready
// until the last beat of a request is queued.
// Reset: synchronous active low; clears the sequencer, output valid and output_enable.
`default_nettype none
module fixed_point_to_ascii_formatter
  import fpa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,   // output_enable
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,      // [31:0] value
  input  wire logic [2:0]  in_tuser,      // [2:0] operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,     // [7:0] out_char
  output logic             out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state_r, state_nxt;
  op_t              op_r, op_nxt;
  logic [BCD_W-1:0] data_r, data_nxt;
  idx_t             k_r, k_nxt;
  logic             minus_r, minus_nxt;
  logic             point_r, point_nxt;
  logic             en_r;
  logic             ov_r, ov_nxt;
  char_t            oc_r, oc_nxt;
  logic             ol_r, ol_nxt;

  logic             accept, slot_free, in_dec, cur_dec, conv_start, conv_done;
  logic [VAL_W-1:0] mag;
  logic [BCD_W-1:0] bcd;
  logic [1:0]       frac;
  idx_t             msd, start_k;
  nib_t             digs [NDIG];

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_dec     = (in_tuser >= OP_DEC) && (in_tuser <= OP_MILLI);
  assign cur_dec    = (op_r >= OP_DEC) && (op_r <= OP_MILLI);
  assign conv_start = accept && en_r && in_dec;
  assign mag        = in_tdata[31] ? (32'd0 - in_tdata) : in_tdata;
  assign slot_free  = !ov_r || out_tready;
  assign frac       = op_r[1:0] - 2'd1;

  fpa_bcd_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_start),
    .bin   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      digs[i] = data_r[4*i +: 4];
    end
  end

  always_comb begin
    msd = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[4*i +: 4] != 4'd0) begin
        msd = IDX_W'(i);
      end
    end
    start_k = (msd > {2'b00, frac}) ? msd : {2'b00, frac};
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    data_nxt  = data_r;
    k_nxt     = k_r;
    minus_nxt = minus_r;
    point_nxt = point_r;
    ov_nxt    = ov_r;
    oc_nxt    = oc_r;
    ol_nxt    = ol_r;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept && en_r) begin
          op_nxt    = in_tuser;
          minus_nxt = in_dec && in_tdata[31];
          point_nxt = 1'b0;
          unique case (in_tuser)
            OP_LIT: begin
              data_nxt  = {32'd0, in_tdata[7:0]};
              k_nxt     = '0;
              state_nxt = ST_EMIT;
            end
            OP_DEC, OP_DECI, OP_CENTI, OP_MILLI: begin
              state_nxt = ST_CONV;
            end
            OP_HEX2: begin
              data_nxt  = {8'd0, in_tdata};
              k_nxt     = IDX_W'(1);
              state_nxt = ST_EMIT;
            end
            OP_HEX4: begin
              data_nxt  = {8'd0, in_tdata};
              k_nxt     = IDX_W'(3);
              state_nxt = ST_EMIT;
            end
            OP_HEX8: begin
              data_nxt  = {8'd0, in_tdata};
              k_nxt     = IDX_W'(7);
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (conv_done) begin
          data_nxt  = bcd;
          k_nxt     = start_k;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ol_nxt = 1'b0;
          priority if (minus_r) begin
            oc_nxt    = CH_MINUS;
            minus_nxt = 1'b0;
          end else if (point_r) begin
            oc_nxt    = CH_POINT;
            point_nxt = 1'b0;
          end else begin
            oc_nxt = (op_r == OP_LIT) ? data_r[7:0] : hex_char(digs[k_r]);
            if (k_r == '0) begin
              ol_nxt    = 1'b1;
              state_nxt = ST_IDLE;
            end else begin
              k_nxt = k_r - IDX_W'(1);
              if (cur_dec && (frac != 2'd0) && (k_r == {2'b00, frac})) begin
                point_nxt = 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      minus_r <= 1'b0;
      point_r <= 1'b0;
      en_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      minus_r <= minus_nxt;
      point_r <= point_nxt;
      ov_r    <= ov_nxt;
      if (cfg_wr_en) begin
        en_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    data_r <= data_nxt;
    k_r    <= k_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = oc_r;
  assign out_tlast  = ol_r;

endmodule
`default_nettype wire

// ----- rtl/core/fpa_checker.sv -----
// Port-level checks for the ASCII formatter, bound to the top level.
`default_nettype none
module fpa_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata,
  input wire logic       out_tlast
);

  logic [3:0] run_r;
  logic       out_hs;

  assign out_hs = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (out_hs) begin
      run_r <= out_tlast ? 4'd0 : run_r + 4'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input ready while a request is still being emitted");

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_hs && (run_r == 4'd11) |-> out_tlast)
    else $error("request produced more than twelve characters");

  a_in_len: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> (run_r == 4'd0) || (out_tvalid && out_tlast))
    else $error("request accepted mid-run");

endmodule

bind fixed_point_to_ascii_formatter fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

// ----- bench/tb_fixed_point_to_ascii_formatter.sv -----
// Self-checking testbench for the fixed-point and hex ASCII formatter.
`timescale 1ns / 100ps
module tb_fixed_point_to_ascii_formatter;
  import fpa_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int DIR_N = 25;

  typedef struct packed {
    op_t         op;
    logic [31:0] val;
    logic [95:0] txt;
  } row_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  beat_t pending_chars[$];
  logic  enable_shadow = 1'b0;
  int    mismatch_cnt = 0;
  int    cyc = 0;
  int    beat_cnt = 0;
  int    hold_left = 0;
  bit    hold_done = 1'b0;

  row_t dir_tab [DIR_N] = '{
    '{OP_LIT,   32'h0000_0000, 96'h0},
    '{OP_LIT,   32'hFFFF_FF25, "%"},
    '{OP_LIT,   32'h0000_00FF, 96'h0},
    '{OP_DEC,   32'h0000_0000, "0"},
    '{OP_DEC,   32'h7FFF_FFFF, "2147483647"},
    '{OP_DEC,   32'h8000_0000, "-2147483648"},
    '{OP_DEC,   32'hFFFF_FFFF, "-1"},
    '{OP_DEC,   32'd1000000000, "1000000000"},
    '{OP_DEC,   32'd999999999, 96'h0},
    '{OP_DECI,  32'd5, "0.5"},
    '{OP_DECI,  32'd0, "0.0"},
    '{OP_DECI,  32'hFFFF_FFFF, "-0.1"},
    '{OP_DECI,  32'h8000_0000, "-214748364.8"},
    '{OP_CENTI, 32'd7, "0.07"},
    '{OP_CENTI, 32'd12345, 96'h0},
    '{OP_CENTI, 32'hFFFF_FF9C, "-1.00"},
    '{OP_MILLI, 32'd7, "0.007"},
    '{OP_MILLI, 32'd0, "0.000"},
    '{OP_MILLI, 32'h7FFF_FFFF, "2147483.647"},
    '{OP_HEX2,  32'h1234_56AB, "AB"},
    '{OP_HEX4,  32'hFFFF_0000, "0000"},
    '{OP_HEX4,  32'h0000_C0DE, 96'h0},
    '{OP_HEX8,  32'hDEAD_BEEF, "DEADBEEF"},
    '{OP_HEX8,  32'h0000_0000, "00000000"},
    '{OP_HEX8,  32'hFFFF_FFFF, "FFFFFFFF"}
  };

  fixed_point_to_ascii_formatter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit stall_now();
    bit calm;
    calm = (cyc >= 5000) && (cyc < 12000);
    return !calm && ($urandom_range(0, 99) < 34);
  endfunction

  function automatic void queue_chars(char_t chars [12], int n);
    for (int i = 0; i < n; i++) begin
      pending_chars.push_back('{chars[i], (i == n - 1)});
    end
  endfunction

  function automatic char_t digit_char(logic [31:0] d);
    return CH_ZERO + char_t'(d);
  endfunction

  function automatic char_t nibble_char(logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + char_t'(nib) : CH_UPPER + char_t'(nib) - 8'd10;
  endfunction

  function automatic void format_request(op_t op, logic [31:0] v);
    char_t       chars [12];
    int          n;
    int          nibs;
    logic [31:0] mag;
    logic [31:0] pw;
    logic [31:0] minpw;
    n = 0;
    mag = v;
    pw = 1;
    minpw = 1;
    nibs = 8;
    if (!enable_shadow) return;
    case (op)
      OP_LIT: begin
        chars[0] = v[7:0];
        n = 1;
      end
      OP_DEC, OP_DECI, OP_CENTI, OP_MILLI: begin
        case (op)
          OP_DECI:  minpw = 10;
          OP_CENTI: minpw = 100;
          OP_MILLI: minpw = 1000;
          default:  minpw = 1;
        endcase
        if (v[31]) begin
          chars[n] = CH_MINUS;
          n++;
          mag = 32'd0 - v;
        end
        while (pw < 32'd1000000000 && (mag / (pw * 10)) != 0) pw = pw * 10;
        if (pw < minpw) pw = minpw;
        while (1) begin
          chars[n] = digit_char((mag / pw) % 10);
          n++;
          if (minpw > 1 && pw == minpw) begin
            chars[n] = CH_POINT;
            n++;
          end
          if (pw == 1) break;
          pw = pw / 10;
        end
      end
      default: begin
        nibs = (op == OP_HEX2) ? 2 : (op == OP_HEX4) ? 4 : 8;
        for (int k = nibs - 1; k >= 0; k--) begin
          chars[n] = nibble_char(v[4*k +: 4]);
          n++;
        end
      end
    endcase
    queue_chars(chars, n);
  endfunction

  function automatic void queue_text(logic [95:0] t);
    char_t chars [12];
    int    n;
    bit    started;
    n = 0;
    started = 1'b0;
    for (int k = 11; k >= 0; k--) begin
      if (started || t[8*k +: 8] != 8'h00) begin
        started = 1'b1;
        chars[n] = t[8*k +: 8];
        n++;
      end
    end
    queue_chars(chars, n);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_cnt < 40) begin
      $display("[%0d] mismatch %s: got %h, expected %h", cyc, what, got, want);
    end
    mismatch_cnt++;
  endtask

  // Hand one request over; returns once it is accepted.
  task automatic send_item(op_t op, logic [31:0] v);
    @(negedge clk);
    while (stall_now()) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = op;
    in_tdata = v;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_enable(logic en);
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    in_tvalid = 1'b0;
    cfg_wr_en = 1'b1;
    cfg_wr_data = en;
    @(posedge clk);
    enable_shadow = en;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] p;
    p = 1;
    case ($urandom_range(0, 6))
      0: return $urandom_range(0, 20);
      1: return 32'd0 - $urandom_range(1, 1000);
      2: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
      end
      3: begin
        repeat ($urandom_range(0, 9)) p = p * 10;
        return 32'd0 - p + $urandom_range(0, 2) - 1;
      end
      4: return 32'h8000_0000 + $urandom_range(0, 3);
      5: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int n);
    op_t         op;
    logic [31:0] v;
    repeat (n) begin
      op = op_t'($urandom_range(0, 7));
      v = rand_value();
      send_item(op, v);
      format_request(op, v);
    end
  endtask

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: random back-pressure plus one long hold once traffic is flowing.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready = 1'b0;
    end else if (hold_left != 0) begin
      out_tready = 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && beat_cnt >= 150) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_tready = 1'b0;
    end else begin
      out_tready = !stall_now();
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      beat_cnt = beat_cnt + 1;
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected beat", {24'h0, out_tdata}, 32'h0);
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== want.ch) begin
          report_mismatch("out_char", {24'h0, out_tdata}, {24'h0, want.ch});
        end
        if (out_tlast !== want.last) begin
          report_mismatch("last", {31'h0, out_tlast}, {31'h0, want.last});
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Output disabled out of reset: drop these.
    send_item(OP_DEC, 32'd42);
    format_request(OP_DEC, 32'd42);
    send_item(OP_HEX8, 32'hFFFF_FFFF);
    format_request(OP_HEX8, 32'hFFFF_FFFF);
    send_item(OP_LIT, 32'h41);
    format_request(OP_LIT, 32'h41);

    write_enable(1'b1);
    for (int i = 0; i < DIR_N; i++) begin
      send_item(dir_tab[i].op, dir_tab[i].val);
      if (dir_tab[i].txt != 96'h0) queue_text(dir_tab[i].txt);
      else format_request(dir_tab[i].op, dir_tab[i].val);
    end

    run_random(170);
    write_enable(1'b0);
    run_random(40);
    write_enable(1'b1);
    run_random(232);

    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/fpa_pkg.sv
rtl/core/fpa_bcd_conv.sv
rtl/core/fixed_point_to_ascii_formatter.sv
rtl/core/fpa_checker.sv
bench/tb_fixed_point_to_ascii_formatter.sv
